// ===== design/r2e_pkg.sv =====
// ---------------------------------------------------------------------------
// r2e_pkg
// Shared widths, constants and the arctangent table for the rotation
// matrix to Euler angle converter.
// ---------------------------------------------------------------------------
`default_nettype none

package r2e_pkg;

  // Datapath width of the CORDIC x and y lanes (Q2.26 plus growth).
  localparam int unsigned XW = 32;
  // Width of the CORDIC angle accumulator, units of 2^-24 rad.
  localparam int unsigned ZW = 32;
  // Width of the wide products.
  localparam int unsigned PW = 64;

  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned CORDIC_STAGES_MAX = 24;

  localparam logic signed [ZW-1:0] ANG_PI     = 32'sd52707179;
  localparam logic signed [PW-1:0] INV_GAIN   = 64'sd652032874;
  localparam logic signed [PW-1:0] DEG_MUL    = 64'sd480631834;

  localparam int unsigned FIELD_W = 16;
  localparam int unsigned THR_W   = 15;

  // round(atan(2^-i) * 2^24)
  function automatic logic signed [ZW-1:0] atan_val(input int unsigned i);
    logic signed [ZW-1:0] v;
    case (i)
      0:       v = 32'sd13176795;
      1:       v = 32'sd7778716;
      2:       v = 32'sd4110060;
      3:       v = 32'sd2086331;
      4:       v = 32'sd1047214;
      5:       v = 32'sd524117;
      6:       v = 32'sd262123;
      7:       v = 32'sd131069;
      8:       v = 32'sd65536;
      9:       v = 32'sd32768;
      10:      v = 32'sd16384;
      11:      v = 32'sd8192;
      12:      v = 32'sd4096;
      13:      v = 32'sd2048;
      14:      v = 32'sd1024;
      15:      v = 32'sd512;
      16:      v = 32'sd256;
      17:      v = 32'sd128;
      18:      v = 32'sd64;
      19:      v = 32'sd32;
      20:      v = 32'sd16;
      21:      v = 32'sd8;
      22:      v = 32'sd4;
      23:      v = 32'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== design/r2e_cordic.sv =====
// ---------------------------------------------------------------------------
// r2e_cordic
// Unrolled vectoring CORDIC: one register per stage, each stage loads on
// its own enable so the surrounding pipeline can stall it stage by stage.
// ---------------------------------------------------------------------------
`default_nettype none

module r2e_cordic #(
  parameter int unsigned STAGES = r2e_pkg::CORDIC_STAGES_DEF
) (
  input  wire                               clk_i,
  input  wire  [STAGES:0]                   en_i,
  input  wire  logic signed [r2e_pkg::XW-1:0] x_i,
  input  wire  logic signed [r2e_pkg::XW-1:0] y_i,
  output logic signed [r2e_pkg::XW-1:0]       mag_o,
  output logic signed [r2e_pkg::ZW-1:0]       ang_o
);
  import r2e_pkg::*;

  logic signed [XW-1:0] x_q [STAGES+1];
  logic signed [XW-1:0] y_q [STAGES+1];
  logic signed [ZW-1:0] z_q [STAGES+1];
  logic                 zero_q [STAGES+1];

  // Pre-rotation into the right half plane.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        x_q[0] <= -x_i;
        y_q[0] <= -y_i;
        z_q[0] <= (y_i >= 0) ? ANG_PI : -ANG_PI;
      end else begin
        x_q[0] <= x_i;
        y_q[0] <= y_i;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i[i+1]) begin
        zero_q[i+1] <= zero_q[i];
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_val(i);
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_val(i);
        end
      end
    end
  end

  assign mag_o = zero_q[STAGES] ? '0 : x_q[STAGES];
  assign ang_o = zero_q[STAGES] ? '0 : z_q[STAGES];

endmodule

`default_nettype wire

// ===== design/rotation_matrix_to_euler_unit.sv =====
// ---------------------------------------------------------------------------
// rotation_matrix_to_euler_unit
// Rotation matrix (Q2.14) to Z-Y-X Euler angles with gimbal-lock handling.
// ---------------------------------------------------------------------------
//
//   channel   dir  handshake             payload
//   s_axis    in   tvalid/tready         tdata: r00 r10 r11 r12 r20 r21 r22
//   m_axis    out  tvalid/tready         tdata: roll pitch yaw, tuser: singular
//   cfg       in   cfg_we_i              cfg_idx_i, cfg_wdata_i
//
// One word is accepted per cycle while the output is not stalled; the two
// CORDIC chains run in series (pitch needs the magnitude sy).
// Reset clears only the stage valid bits and presets the configuration registers.
// Each stage holds its word while the next stage is full and stalled, so a
// stall at the output backs up stage by stage and bubbles are squeezed out.
// ---------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_euler_unit #(
  parameter int unsigned CORDIC_STAGES = r2e_pkg::CORDIC_STAGES_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata fields from bit 0: r00, r10, r11, r12, r20, r21, r22 (16 bits each)
  input  wire  [111:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // tdata fields from bit 0: roll, pitch, yaw (16 bits each)
  output logic [47:0] m_axis_tdata,
  // tuser fields from bit 0: singular
  output logic [0:0]  m_axis_tuser,
  input  wire         cfg_we_i,
  input  wire  [0:0]  cfg_idx_i,
  input  wire  [14:0] cfg_wdata_i
);
  import r2e_pkg::*;

  localparam int unsigned N    = CORDIC_STAGES;
  localparam int unsigned ST_M = N + 1;       // gain multiply
  localparam int unsigned ST_S = N + 2;       // sy, singular decision
  localparam int unsigned ST_B = N + 3;       // first pitch CORDIC stage
  localparam int unsigned ST_C = 2 * N + 4;   // unit conversion multiply
  localparam int unsigned ST_O = 2 * N + 5;   // output register
  localparam int unsigned T    = 2 * N + 6;

  localparam logic [0:0] CFG_UNIT = 1'b0;
  localparam logic [0:0] CFG_THR  = 1'b1;

  // Configuration registers.
  logic              unit_q;
  logic [THR_W-1:0]  thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q <= 1'b1;
      thr_q  <= THR_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_UNIT: unit_q <= cfg_wdata_i[0];
        CFG_THR:  thr_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Stage valid bits and the backward ready chain.
  logic [T-1:0] v_q;
  logic [T:0]   rdy;

  assign rdy[T] = m_axis_tready;
  for (genvar k = 0; k < T; k++) begin : g_rdy
    assign rdy[k] = !v_q[k] || rdy[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < T; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = v_q[T-1];

  // Input unpacking into Q2.26.
  function automatic logic signed [XW-1:0] scale_in(input logic [FIELD_W-1:0] f);
    return {{(XW-FIELD_W-12){f[FIELD_W-1]}}, f, 12'b0};
  endfunction

  logic signed [XW-1:0] r00, r10, r11, r12, r21, r22;
  assign r00 = scale_in(s_axis_tdata[15:0]);
  assign r10 = scale_in(s_axis_tdata[31:16]);
  assign r11 = scale_in(s_axis_tdata[47:32]);
  assign r12 = scale_in(s_axis_tdata[63:48]);
  assign r21 = scale_in(s_axis_tdata[95:80]);
  assign r22 = scale_in(s_axis_tdata[111:96]);

  // First CORDIC segment: yaw and both roll candidates run side by side.
  logic signed [XW-1:0] yaw_mag, rn_mag, rs_mag;
  logic signed [ZW-1:0] yaw_ang, rn_ang, rs_ang;

  r2e_cordic #(.STAGES(N)) u_yaw (
    .clk_i (clk_i), .en_i (rdy[N:0]), .x_i (r00), .y_i (r10),
    .mag_o (yaw_mag), .ang_o (yaw_ang)
  );

  r2e_cordic #(.STAGES(N)) u_roll_n (
    .clk_i (clk_i), .en_i (rdy[N:0]), .x_i (r22), .y_i (r21),
    .mag_o (rn_mag), .ang_o (rn_ang)
  );

  r2e_cordic #(.STAGES(N)) u_roll_s (
    .clk_i (clk_i), .en_i (rdy[N:0]), .x_i (r11), .y_i (-r12),
    .mag_o (rs_mag), .ang_o (rs_ang)
  );

  // r20 rides alongside the first segment.
  logic [FIELD_W-1:0] r20_q [N+2];
  always_ff @(posedge clk_i) begin
    if (rdy[0]) r20_q[0] <= s_axis_tdata[79:64];
    for (int k = 1; k <= N + 1; k++) begin
      if (rdy[k]) r20_q[k] <= r20_q[k-1];
    end
  end

  // Gain compensation multiply.
  logic signed [PW-1:0] prod_q;
  logic signed [ZW-1:0] m_yaw_q, m_rn_q, m_rs_q;
  always_ff @(posedge clk_i) begin
    if (rdy[ST_M]) begin
      prod_q  <= PW'(yaw_mag) * INV_GAIN;
      m_yaw_q <= yaw_ang;
      m_rn_q  <= rn_ang;
      m_rs_q  <= rs_ang;
    end
  end

  // Magnitude rounding and the gimbal-lock decision.
  logic signed [PW-1:0] sy;
  logic                 sing;
  assign sy   = (prod_q + (PW'(1) <<< 29)) >>> 30;
  assign sing = sy < $signed({{(PW-THR_W-12){1'b0}}, thr_q, 12'b0});

  logic signed [XW-1:0] s_sy_q, s_py_q;
  logic signed [ZW-1:0] s_roll_q, s_yaw_q;
  logic                 s_sing_q;
  always_ff @(posedge clk_i) begin
    if (rdy[ST_S]) begin
      s_sy_q   <= XW'(sy);
      s_py_q   <= -scale_in(r20_q[N+1]);
      s_roll_q <= sing ? m_rs_q : m_rn_q;
      s_yaw_q  <= sing ? '0 : m_yaw_q;
      s_sing_q <= sing;
    end
  end

  // Second CORDIC segment: pitch from (sy, -r20).
  logic signed [XW-1:0] p_mag;
  logic signed [ZW-1:0] p_ang;

  r2e_cordic #(.STAGES(N)) u_pitch (
    .clk_i (clk_i), .en_i (rdy[ST_B+N:ST_B]), .x_i (s_sy_q), .y_i (s_py_q),
    .mag_o (p_mag), .ang_o (p_ang)
  );

  logic signed [ZW-1:0] b_roll_q [N+1];
  logic signed [ZW-1:0] b_yaw_q  [N+1];
  logic                 b_sing_q [N+1];
  always_ff @(posedge clk_i) begin
    if (rdy[ST_B]) begin
      b_roll_q[0] <= s_roll_q;
      b_yaw_q[0]  <= s_yaw_q;
      b_sing_q[0] <= s_sing_q;
    end
    for (int k = 1; k <= N; k++) begin
      if (rdy[ST_B+k]) begin
        b_roll_q[k] <= b_roll_q[k-1];
        b_yaw_q[k]  <= b_yaw_q[k-1];
        b_sing_q[k] <= b_sing_q[k-1];
      end
    end
  end

  // Unit conversion: multiply and bias, then shift in the output stage.
  function automatic logic signed [PW-1:0] unit_pre(input logic signed [ZW-1:0] z,
                                                    input logic deg);
    return deg ? (PW'(z) * DEG_MUL + (PW'(1) <<< 39)) : (PW'(z) + PW'(2048));
  endfunction

  function automatic logic [FIELD_W-1:0] unit_post(input logic signed [PW-1:0] p,
                                                   input logic deg);
    logic signed [PW-1:0] s;
    s = deg ? (p >>> 40) : (p >>> 12);
    return s[FIELD_W-1:0];
  endfunction

  logic signed [PW-1:0] c_roll_q, c_pitch_q, c_yaw_q;
  logic                 c_sing_q;
  always_ff @(posedge clk_i) begin
    if (rdy[ST_C]) begin
      c_roll_q  <= unit_pre(b_roll_q[N], unit_q);
      c_pitch_q <= unit_pre(p_ang, unit_q);
      c_yaw_q   <= unit_pre(b_yaw_q[N], unit_q);
      c_sing_q  <= b_sing_q[N];
    end
  end

  logic [47:0] o_data_q;
  logic        o_sing_q;
  always_ff @(posedge clk_i) begin
    if (rdy[ST_O]) begin
      o_data_q <= {unit_post(c_yaw_q, unit_q), unit_post(c_pitch_q, unit_q),
                   unit_post(c_roll_q, unit_q)};
      o_sing_q <= c_sing_q;
    end
  end

  assign m_axis_tdata = o_data_q;
  assign m_axis_tuser = o_sing_q;

  // The pitch lane needs only the angle; its magnitude and the roll
  // magnitudes feed nothing further.
  logic unused_mag;
  assign unused_mag = ^{p_mag, rn_mag, rs_mag};

  // With an empty output stage the pipeline can always take a word.
  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output stage empty");

  // The singular branch always reports a zero yaw.
  a_yaw0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[47:32] == 16'd0))
    else $error("nonzero yaw on singular result");

  // A word accepted on an empty pipeline lands in the first stage.
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v_q[0])
    else $error("accepted word lost at first stage");

endmodule

`default_nettype wire
